FILE: rtl/rmst_pkg.sv
// Shared types, constants and codes for the range maximum segment tree.
package rmst_pkg;

    localparam int LEAVES  = 1024;
    localparam int LEVELS  = $clog2(LEAVES);
    localparam int NODE_W  = LEVELS + 1;      // node index 0 .. 2*LEAVES-1
    localparam int QIDX_W  = LEVELS + 2;      // query bound may reach 2*LEAVES
    localparam int DEPTH   = 2 * LEAVES;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 10;
    localparam int CNT_W   = 11;
    localparam int CMD_W   = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1024);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET = 2'd0,
        CMD_GET = 2'd1,
        CMD_QRY = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] new_value;
        logic [CNT_W-1:0] range_start;
        logic [CNT_W-1:0] range_end;
    } t_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic leaf_wr;
        logic pair_rd;
        logic node_wr;
        logic leaf_rd;
        logic qry_rd;
        logic qry_acc;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic             clr_last;
        logic [CMD_W-1:0] cmd;
        logic             err;
        logic             k_root;
        logic             l_lt_r;
        logic             out_free;
    } t_dp_stat;

endpackage

FILE: rtl/range_max_segment_tree_unit.sv
// Top level of the range maximum segment tree unit.
// Holds 1024 unsigned 32-bit elements in a bottom-up segment tree (2048-node
// store, node 1 the root, leaf i at node 1024+i) and runs one command per input
// transfer: set a leaf (tuser 0), get a leaf (tuser 1) or return the maximum
// over the half-open range [range_start, range_end) (tuser 2). Every command
// gives exactly one result transfer; an index or range outside active_count
// (clamped to 1024), or an unknown command, returns zero with status 1 and
// leaves the tree unchanged, and an empty in-bounds range returns zero, status
// 0. After reset the unit runs a clearing pass over all 2048 nodes, one node per
// cycle, before it takes its first item; configuration writes are taken at any
// time but must only be issued while the unit is idle. Items are worked one at
// a time through a single store with one write and two read ports: a set writes
// the leaf and then, for each of the ten tree levels, reads the sibling pair and
// writes their maximum to the parent; a get reads the leaf; a query walks the
// levels while its bounds stay apart, reading the two boundary nodes per level.
// The result sits in an output register so the unit returns to idle while
// it waits for the downstream side.
module range_max_segment_tree_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command transfer
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [9:0] position, [41:10] new_value, [52:42] range_start, [63:53] range_end
    input  logic [63:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_axis_tuser,
    // result transfer
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] result_value
    output logic [31:0] o_m_axis_tdata,
    // [0] status
    output logic        o_m_axis_tuser,
    // active_count register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data
);
    import rmst_pkg::*;

    t_item    w_item;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // unpack the command transfer
    assign w_item.command     = i_s_axis_tuser;
    assign w_item.position    = i_s_axis_tdata[9:0];
    assign w_item.new_value   = i_s_axis_tdata[41:10];
    assign w_item.range_start = i_s_axis_tdata[52:42];
    assign w_item.range_end   = i_s_axis_tdata[63:53];

    // configuration must only be written while idle (not enforced here), so always take it
    assign o_cfg_ready = 1'b1;

    rmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rmst_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_item      (w_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_value (o_m_axis_tdata),
        .o_out_err   (o_m_axis_tuser)
    );

endmodule

FILE: rtl/rmst_ctrl.sv
// Sequencer for the segment tree: clearing pass, set, get and query walks.
module rmst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rmst_pkg::t_dp_stat i_stat,
    output rmst_pkg::t_dp_cmd  o_cmd
);
    import rmst_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SET_LEAF,
        ST_SET_READ,
        ST_SET_WRITE,
        ST_GET_READ,
        ST_QRY_STEP,
        ST_QRY_ACC,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_stat.err) begin
                    n_state = ST_FINISH;
                end else begin
                    unique case (i_stat.cmd)
                        CMD_SET: n_state = ST_SET_LEAF;
                        CMD_GET: n_state = ST_GET_READ;
                        CMD_QRY: n_state = ST_QRY_STEP;
                        default: n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SET_LEAF: begin
                o_cmd.leaf_wr = 1'b1;
                n_state       = ST_SET_READ;
            end
            ST_SET_READ: begin
                o_cmd.pair_rd = 1'b1;
                n_state       = ST_SET_WRITE;
            end
            ST_SET_WRITE: begin
                o_cmd.node_wr = 1'b1;
                n_state       = i_stat.k_root ? ST_FINISH : ST_SET_READ;
            end
            ST_GET_READ: begin
                o_cmd.leaf_rd = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_QRY_STEP: begin
                if (i_stat.l_lt_r) begin
                    o_cmd.qry_rd = 1'b1;
                    n_state      = ST_QRY_ACC;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_QRY_ACC: begin
                o_cmd.qry_acc = 1'b1;
                n_state       = ST_QRY_STEP;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/rmst_dpath.sv
// Tree store, index registers, accumulators, bound checks and result register.
module rmst_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmst_pkg::t_dp_cmd              i_cmd,
    output rmst_pkg::t_dp_stat             o_stat,
    input  rmst_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [rmst_pkg::CNT_W-1:0]     i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rmst_pkg::VAL_W-1:0]     o_out_value,
    output logic                           o_out_err
);
    import rmst_pkg::*;

    logic [VAL_W-1:0]  r_mem [DEPTH];
    logic [VAL_W-1:0]  r_rd_a, r_rd_b;

    logic [CNT_W-1:0]  r_active_count;
    logic [NODE_W-1:0] r_clr_addr;
    logic [CMD_W-1:0]  r_cmd;
    logic              r_err;
    logic [VAL_W-1:0]  r_val;
    logic [NODE_W-1:0] r_k;
    logic [QIDX_W-1:0] r_l, r_r;
    logic              r_use_a, r_use_b;
    logic [VAL_W-1:0]  r_acc_l, r_acc_r;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_err;

    logic [CNT_W-1:0]  n_eff;
    logic              n_err;
    logic              n_we;
    logic [NODE_W-1:0] n_waddr;
    logic [VAL_W-1:0]  n_wdata;
    logic [NODE_W-1:0] n_raddr_a, n_raddr_b;
    logic              n_re;
    logic [VAL_W-1:0]  n_pair_max;
    logic [VAL_W-1:0]  n_res;
    logic [QIDX_W-1:0] n_r_dec;

    // bound checks against the count clamped to capacity
    always_comb begin
        n_eff = (r_active_count > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : r_active_count;
        unique case (i_item.command) inside
            CMD_SET, CMD_GET: n_err = !(CNT_W'(i_item.position) < n_eff);
            CMD_QRY:          n_err = !((i_item.range_start <= i_item.range_end) &&
                                        (i_item.range_end <= n_eff));
            default:          n_err = 1'b1;
        endcase
    end

    assign n_pair_max = (r_rd_a > r_rd_b) ? r_rd_a : r_rd_b;
    assign n_r_dec    = r_r - QIDX_W'(1);

    // store port selection
    always_comb begin
        n_we      = i_cmd.clr_wr | i_cmd.leaf_wr | i_cmd.node_wr;
        n_waddr   = r_k;
        n_wdata   = n_pair_max;
        if (i_cmd.clr_wr) begin
            n_waddr = r_clr_addr;
            n_wdata = '0;
        end else if (i_cmd.leaf_wr) begin
            n_wdata = r_val;
        end
        n_re      = i_cmd.pair_rd | i_cmd.leaf_rd | i_cmd.qry_rd;
        n_raddr_a = r_k;
        n_raddr_b = {r_k[NODE_W-1:1], 1'b1};
        if (i_cmd.pair_rd) begin
            n_raddr_a = {r_k[NODE_W-1:1], 1'b0};
        end else if (i_cmd.qry_rd) begin
            n_raddr_a = r_l[NODE_W-1:0];
            n_raddr_b = n_r_dec[NODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        if (n_re) begin
            r_rd_a <= r_mem[n_raddr_a];
            r_rd_b <= r_mem[n_raddr_b];
        end
    end

    always_comb begin
        n_res = '0;
        if (!r_err) begin
            case (r_cmd)
                CMD_GET: n_res = r_rd_a;
                CMD_QRY: n_res = (r_acc_l > r_acc_r) ? r_acc_l : r_acc_r;
                default: n_res = '0;
            endcase
        end
    end

    // item registers, walk indices and accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_item.command;
            r_err   <= n_err;
            r_val   <= i_item.new_value;
            r_k     <= NODE_W'(LEAVES) + NODE_W'(i_item.position);
            r_l     <= QIDX_W'(LEAVES) + QIDX_W'(i_item.range_start);
            r_r     <= QIDX_W'(LEAVES) + QIDX_W'(i_item.range_end);
            r_acc_l <= '0;
            r_acc_r <= '0;
        end
        if (i_cmd.pair_rd) begin
            r_k <= r_k >> 1;
        end
        if (i_cmd.qry_rd) begin
            r_use_a <= r_l[0];
            r_use_b <= r_r[0];
            r_l     <= (r_l + QIDX_W'(r_l[0])) >> 1;
            r_r     <= r_r >> 1;
        end
        if (i_cmd.qry_acc) begin
            if (r_use_a && (r_rd_a > r_acc_l)) begin
                r_acc_l <= r_rd_a;
            end
            if (r_use_b && (r_rd_b > r_acc_r)) begin
                r_acc_r <= r_rd_b;
            end
        end
        if (i_cmd.out_load) begin
            r_out_value <= n_res;
            r_out_err   <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= CNT_RESET;
            r_clr_addr     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active_count <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + NODE_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.clr_last = &r_clr_addr;
    assign o_stat.cmd      = r_cmd;
    assign o_stat.err      = r_err;
    assign o_stat.k_root   = (r_k == NODE_W'(1));
    assign o_stat.l_lt_r   = (r_l < r_r);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_err   = r_out_err;

`ifndef ASSERT_OFF
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.leaf_wr, i_cmd.node_wr}))
        else $error("more than one store write source");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_acc_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.qry_acc |-> $past(i_cmd.qry_rd))
        else $error("accumulate without a preceding node read");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == '0))
        else $error("error result carries a nonzero value");
`endif

endmodule
